// ===== hdl/tpds_pkg.sv =====
package tpds_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_e;

  localparam logic [7:0] TAG_SPECIFIER  = 8'h5f;
  localparam logic [7:0] TAG_TABLE_PIDS = 8'hd1;
  localparam logic [7:0] SPEC_LEN       = 8'd4;
  localparam logic [2:0] SPEC_IDX_FULL  = 3'd4;
  localparam logic [2:0] SPEC_IDX_MAX   = 3'd7;
  localparam logic [2:0] RPT_SUMMARY    = 3'd0;

  localparam logic [7:0] SPEC_BYTES [4] = '{8'h46, 8'h53, 8'h41, 8'h54};

  localparam int unsigned PID_W      = 13;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned IN_TUSER_W = 3;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 3;

endpackage

// ===== hdl/table_pid_descriptor_scanner_unit.sv =====
// Channel   | Dir | Signals                           | Contents
// s_axis    | in  | tvalid tready tdata tuser tlast   | one loop byte or scan marker
// m_axis    | out | tvalid tready tdata tuser         | table report or end summary
//
// One input transaction per cycle unless the result stalls; the result register drives m_axis.
// The input register feeds the parse step; the result register holds its output.
// Reset clears the specifier flag, parse state and both valid flags.
// A stalled result holds the parse step; the input register still takes a
// transaction while empty.
module table_pid_descriptor_scanner_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] data_byte, [20:8] stream_pid, [23:21] zero
  input  logic [tpds_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [1:0] kind, [2] loop_first
  input  logic [tpds_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  // loop_last
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [12:0] found_pid, [13] private_match, [15:14] zero
  output logic [tpds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [2:0] report_kind
  output logic [tpds_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);

  logic                            in_vld_q;
  logic [1:0]                      in_kind_q;
  logic [7:0]                      in_byte_q;
  logic [tpds_pkg::PID_W-1:0]      in_pid_q;
  logic                            in_first_q;
  logic                            in_last_q;

  logic                            flag_q, flag_d;
  tpds_pkg::phase_e                phase_q, phase_d, phase_cur;
  logic [7:0]                      tag_q, tag_d;
  logic [7:0]                      left_q, left_d, left_dec;
  logic [2:0]                      idx_q, idx_d;
  logic                            match_q, match_d;

  logic                            res_vld;
  logic [2:0]                      res_kind;
  logic [tpds_pkg::PID_W-1:0]      res_pid;
  logic                            res_match;
  logic                            reporting;

  logic                            out_vld_q;
  logic [2:0]                      out_kind_q;
  logic [tpds_pkg::PID_W-1:0]      out_pid_q;
  logic                            out_match_q;

  logic                            advance;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q  <= s_axis_tuser_i[1:0];
      in_first_q <= s_axis_tuser_i[2];
      in_byte_q  <= s_axis_tdata_i[7:0];
      in_pid_q   <= s_axis_tdata_i[20:8];
      in_last_q  <= s_axis_tlast_i;
    end
  end

  assign reporting = (tag_q == tpds_pkg::TAG_TABLE_PIDS) && flag_q;
  assign left_dec  = left_q - 8'd1;

  always_comb begin
    flag_d    = flag_q;
    phase_d   = phase_q;
    tag_d     = tag_q;
    left_d    = left_q;
    idx_d     = idx_q;
    match_d   = match_q;
    res_vld   = 1'b0;
    res_kind  = tpds_pkg::RPT_SUMMARY;
    res_pid   = '0;
    res_match = flag_q;
    phase_cur = in_first_q ? tpds_pkg::PH_TAG : phase_q;
    unique case (in_kind_q)
      tpds_pkg::KIND_START: begin
        flag_d  = 1'b0;
        phase_d = tpds_pkg::PH_TAG;
        tag_d   = '0;
        left_d  = '0;
        idx_d   = '0;
        match_d = 1'b1;
      end
      tpds_pkg::KIND_END: begin
        phase_d = tpds_pkg::PH_TAG;
        tag_d   = '0;
        left_d  = '0;
        idx_d   = '0;
        match_d = 1'b1;
        res_vld = 1'b1;
      end
      tpds_pkg::KIND_BYTE: begin
        phase_d = phase_cur;
        unique case (phase_cur)
          tpds_pkg::PH_TAG: begin
            tag_d   = in_byte_q;
            phase_d = tpds_pkg::PH_LEN;
          end
          tpds_pkg::PH_LEN: begin
            if (tag_q == tpds_pkg::TAG_SPECIFIER) begin
              flag_d  = 1'b0;
              match_d = (in_byte_q == tpds_pkg::SPEC_LEN);
              idx_d   = '0;
            end
            if (in_byte_q == 8'd0) begin
              phase_d = reporting ? tpds_pkg::PH_SKIP : tpds_pkg::PH_TAG;
            end else begin
              left_d  = in_byte_q;
              phase_d = tpds_pkg::PH_BODY;
            end
          end
          tpds_pkg::PH_BODY: begin
            if (tag_q == tpds_pkg::TAG_SPECIFIER) begin
              if (!idx_q[2] && in_byte_q != tpds_pkg::SPEC_BYTES[idx_q[1:0]]) begin
                match_d = 1'b0;
              end
              if (idx_q != tpds_pkg::SPEC_IDX_MAX) begin
                idx_d = idx_q + 3'd1;
              end
            end
            if (reporting && in_byte_q[7:3] == 5'd0 && in_byte_q[2:0] != 3'd0) begin
              res_vld  = 1'b1;
              res_kind = in_byte_q[2:0];
              res_pid  = in_pid_q;
            end
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              if (tag_q == tpds_pkg::TAG_SPECIFIER && match_d
                  && idx_d == tpds_pkg::SPEC_IDX_FULL) begin
                flag_d = 1'b1;
              end
              phase_d = reporting ? tpds_pkg::PH_SKIP : tpds_pkg::PH_TAG;
            end
          end
          tpds_pkg::PH_SKIP: begin
          end
          default: begin
          end
        endcase
        if (in_last_q) begin
          phase_d = tpds_pkg::PH_TAG;
          left_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= 1'b0;
      phase_q <= tpds_pkg::PH_TAG;
      tag_q   <= '0;
      left_q  <= '0;
      idx_q   <= '0;
      match_q <= 1'b1;
    end else if (advance) begin
      flag_q  <= flag_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q  <= res_kind;
      out_pid_q   <= res_pid;
      out_match_q <= res_match;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_match_q, out_pid_q};
  assign m_axis_tuser_o  = out_kind_q;

  a_report_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != tpds_pkg::RPT_SUMMARY |-> m_axis_tdata_o[13])
    else $error("table report without specifier flag");

  a_summary_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == tpds_pkg::RPT_SUMMARY
    |-> m_axis_tdata_o[12:0] == '0)
    else $error("summary carries a PID");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_kind_q == tpds_pkg::KIND_START |=> !flag_q && !out_vld_q)
    else $error("scan start left flag or result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !m_axis_tready_i |=> $stable(flag_q) && $stable(phase_q))
    else $error("parse state moved while result stalled");

endmodule
